[rtl/plcs_pkg.sv]
// Shared constants and register codes for the piecewise linear contrast stretch.
package plcs_pkg;

  typedef enum logic [1:0] {
    REG_IN_LOW   = 2'd0,
    REG_IN_HIGH  = 2'd1,
    REG_OUT_LOW  = 2'd2,
    REG_OUT_HIGH = 2'd3
  } reg_idx_e;

  localparam int unsigned ADDR_BITS    = 4;
  localparam int unsigned IN_LOW_RST   = 50;
  localparam int unsigned IN_HIGH_RST  = 110;
  localparam int unsigned OUT_LOW_RST  = 10;
  localparam int unsigned OUT_HIGH_RST = 110;
  localparam int unsigned QUEUE_DEPTH  = 4;

endpackage

[rtl/plcs_in_if.sv]
// Request channel that carries input pixels.
interface plcs_in_if #(
  parameter int unsigned PIXEL_BITS = 8
) ();
  logic                  valid;
  logic                  ready;
  logic [PIXEL_BITS-1:0] pixel_in;

  modport source (output valid, output pixel_in, input ready);
  modport sink (input valid, input pixel_in, output ready);
endinterface

[rtl/plcs_out_if.sv]
// Request channel that carries stretched pixels.
interface plcs_out_if #(
  parameter int unsigned PIXEL_BITS = 8
) ();
  logic                  valid;
  logic                  ready;
  logic [PIXEL_BITS-1:0] pixel_out;

  modport source (output valid, output pixel_out, input ready);
  modport sink (input valid, input pixel_out, output ready);
endinterface

[rtl/plcs_front.sv]
// Front end: accepts pixels, picks the segment and forms the interpolation product.
module plcs_front #(
  parameter int unsigned PIXEL_BITS = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  plcs_in_if.sink               in_i,
  input  logic [PIXEL_BITS-1:0] x1_i,
  input  logic [PIXEL_BITS-1:0] x2_i,
  input  logic [PIXEL_BITS-1:0] y1_i,
  input  logic [PIXEL_BITS-1:0] y2_i,
  input  logic                  full_i,
  output logic                  push_o,
  output logic [4*PIXEL_BITS:0] entry_o
);

  localparam logic [PIXEL_BITS-1:0] MaxV = {PIXEL_BITS{1'b1}};

  logic [PIXEL_BITS-1:0] xa, ya, xb, yb, span, dp, mag;
  logic signed [PIXEL_BITS:0] dy;
  logic                  neg;

  logic                    vld_q;
  logic [PIXEL_BITS-1:0]   ya_q, mag_q, dp_q, dvs_q;
  logic                    neg_q;
  logic [2*PIXEL_BITS-1:0] num;

  always_comb begin
    if (in_i.pixel_in <= x1_i) begin
      xa = '0;
      ya = '0;
      xb = x1_i;
      yb = y1_i;
    end else if (in_i.pixel_in <= x2_i) begin
      xa = x1_i;
      ya = y1_i;
      xb = x2_i;
      yb = y2_i;
    end else begin
      xa = x2_i;
      ya = y2_i;
      xb = MaxV;
      yb = MaxV;
    end
    span = xb - xa;
    dp   = in_i.pixel_in - xa;
    dy   = $signed({1'b0, yb}) - $signed({1'b0, ya});
    neg  = dy[PIXEL_BITS];
    mag  = neg ? PIXEL_BITS'(-dy) : dy[PIXEL_BITS-1:0];
  end

  assign in_i.ready = !vld_q || !full_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (in_i.ready) begin
      vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      ya_q  <= ya;
      neg_q <= neg;
      dp_q  <= dp;
      if (span == '0) begin
        mag_q <= '0;
        dvs_q <= PIXEL_BITS'(1);
      end else begin
        mag_q <= mag;
        dvs_q <= span;
      end
    end
  end

  assign num     = (2*PIXEL_BITS)'(mag_q) * (2*PIXEL_BITS)'(dp_q);
  assign push_o  = vld_q && !full_i;
  assign entry_o = {ya_q, neg_q, num, dvs_q};

endmodule

[rtl/plcs_queue.sv]
// Short queue between the front end and the divider pipeline.
module plcs_queue #(
  parameter int unsigned WIDTH = 33
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);
  import plcs_pkg::*;

  localparam int unsigned PtrBits = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CntBits = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PtrBits-1:0] LastPtr = PtrBits'(QUEUE_DEPTH - 1);
  localparam logic [CntBits-1:0] FullCnt = CntBits'(QUEUE_DEPTH);

  logic [WIDTH-1:0]   mem_q [QUEUE_DEPTH];
  logic [PtrBits-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntBits-1:0] cnt_q;
  logic               wr, rd;

  assign full_o  = (cnt_q == FullCnt);
  assign empty_o = (cnt_q == '0);
  assign wr      = push_i && !full_o;
  assign rd      = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (wr) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (rd) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      if (wr && !rd) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (rd && !wr) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= FullCnt)
    else $error("queue fill count above depth");
  a_cnt_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr && !rd |=> cnt_q == $past(cnt_q) + 1'b1)
    else $error("queue fill count did not rise on write");
  a_cnt_down: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd && !wr |=> cnt_q == $past(cnt_q) - 1'b1)
    else $error("queue fill count did not fall on read");

endmodule

[rtl/plcs_back.sv]
// Back end: pipelined floor division, offset, clamp and output register.
module plcs_back #(
  parameter int unsigned PIXEL_BITS = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  empty_i,
  input  logic [4*PIXEL_BITS:0] rdata_i,
  output logic                  pop_o,
  plcs_out_if.source            out_o
);

  localparam int unsigned Pb = PIXEL_BITS;
  localparam logic [Pb-1:0] MaxV = {Pb{1'b1}};

  logic            vld_q [Pb+1];
  logic [2*Pb-1:0] rem_q [Pb+1];
  logic [Pb-1:0]   quo_q [Pb+1];
  logic [Pb-1:0]   dvs_q [Pb+1];
  logic [Pb-1:0]   ya_q  [Pb+1];
  logic            neg_q [Pb+1];

  logic [2*Pb-1:0] rem_d [Pb+1];
  logic [Pb-1:0]   quo_d [Pb+1];

  logic                en;
  logic                out_vld_q;
  logic [Pb-1:0]       out_pix_q, pix_d;
  logic [Pb:0]         adj;
  logic signed [Pb+1:0] sum;

  assign en    = !out_vld_q || out_o.ready;
  assign pop_o = en && !empty_i;

  assign rem_d[0] = rdata_i[3*Pb-1:Pb];
  assign quo_d[0] = '0;

  for (genvar j = 1; j <= Pb; j++) begin : g_div
    logic [2*Pb-1:0] trial;
    assign trial = (2*Pb)'(dvs_q[j-1]) << (Pb - j);
    always_comb begin
      rem_d[j] = rem_q[j-1];
      quo_d[j] = quo_q[j-1];
      if (rem_q[j-1] >= trial) begin
        rem_d[j]        = rem_q[j-1] - trial;
        quo_d[j][Pb-j]  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= Pb; k++) begin
        vld_q[k] <= 1'b0;
      end
    end else if (en) begin
      vld_q[0] <= !empty_i;
      for (int k = 1; k <= Pb; k++) begin
        vld_q[k] <= vld_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rem_q[0] <= rem_d[0];
      quo_q[0] <= quo_d[0];
      dvs_q[0] <= rdata_i[Pb-1:0];
      neg_q[0] <= rdata_i[3*Pb];
      ya_q[0]  <= rdata_i[4*Pb:3*Pb+1];
      for (int k = 1; k <= Pb; k++) begin
        rem_q[k] <= rem_d[k];
        quo_q[k] <= quo_d[k];
        dvs_q[k] <= dvs_q[k-1];
        neg_q[k] <= neg_q[k-1];
        ya_q[k]  <= ya_q[k-1];
      end
    end
  end

  always_comb begin
    adj = (Pb+1)'(quo_q[Pb]) + (Pb+1)'(neg_q[Pb] && (rem_q[Pb] != '0));
    if (neg_q[Pb]) begin
      sum = $signed({2'b00, ya_q[Pb]}) - $signed({1'b0, adj});
    end else begin
      sum = $signed({2'b00, ya_q[Pb]}) + $signed({1'b0, adj});
    end
    if (sum < 0) begin
      pix_d = '0;
    end else if (sum > $signed({2'b00, MaxV})) begin
      pix_d = MaxV;
    end else begin
      pix_d = sum[Pb-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= vld_q[Pb];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_pix_q <= pix_d;
    end
  end

  assign out_o.valid     = out_vld_q;
  assign out_o.pixel_out = out_pix_q;

endmodule

[rtl/piecewise_linear_contrast_stretch.sv]
// Top level of the piecewise linear contrast stretch with its breakpoint registers.
// Each result passes the front-end register, queue, divider stages and output register.
// One request is taken per cycle when the output is not stalled; the quotient is formed
// one bit per pipeline stage, and a four-entry queue decouples front end and divider.
// Reset sets the breakpoints to (50,10) and (110,110) and empties pipeline and queue.
module piecewise_linear_contrast_stretch #(
  parameter int unsigned PIXEL_BITS = 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  plcs_in_if.sink                        in_i,
  plcs_out_if.source                     out_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [plcs_pkg::ADDR_BITS-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);
  import plcs_pkg::*;

  localparam int unsigned EntryW = 4*PIXEL_BITS + 1;

  logic [PIXEL_BITS-1:0] x1_q, x2_q, y1_q, y2_q;
  reg_idx_e              reg_idx;
  logic                  wr_en;

  logic              push, full, pop, empty;
  logic [EntryW-1:0] wdata, rdata;

  assign reg_idx = reg_idx_e'(paddr[ADDR_BITS-1:2]);
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x1_q <= PIXEL_BITS'(IN_LOW_RST);
      x2_q <= PIXEL_BITS'(IN_HIGH_RST);
      y1_q <= PIXEL_BITS'(OUT_LOW_RST);
      y2_q <= PIXEL_BITS'(OUT_HIGH_RST);
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_IN_LOW:   x1_q <= pwdata[PIXEL_BITS-1:0];
        REG_IN_HIGH:  x2_q <= pwdata[PIXEL_BITS-1:0];
        REG_OUT_LOW:  y1_q <= pwdata[PIXEL_BITS-1:0];
        REG_OUT_HIGH: y2_q <= pwdata[PIXEL_BITS-1:0];
        default:      x1_q <= x1_q;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_IN_LOW:   prdata = 32'(x1_q);
      REG_IN_HIGH:  prdata = 32'(x2_q);
      REG_OUT_LOW:  prdata = 32'(y1_q);
      REG_OUT_HIGH: prdata = 32'(y2_q);
      default:      prdata = '0;
    endcase
  end

  plcs_front #(
    .PIXEL_BITS(PIXEL_BITS)
  ) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .x1_i   (x1_q),
    .x2_i   (x2_q),
    .y1_i   (y1_q),
    .y2_i   (y2_q),
    .full_i (full),
    .push_o (push),
    .entry_o(wdata)
  );

  plcs_queue #(
    .WIDTH(EntryW)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .wdata_i(wdata),
    .full_o (full),
    .pop_i  (pop),
    .rdata_o(rdata),
    .empty_o(empty)
  );

  plcs_back #(
    .PIXEL_BITS(PIXEL_BITS)
  ) u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .empty_i(empty),
    .rdata_i(rdata),
    .pop_o  (pop),
    .out_o  (out_o)
  );

endmodule
